/* rtl/core/pcs_pkg.sv */
// Shared types and constants for the polygon clipper.
package pcs_pkg;

  localparam int COORD_W     = 32;
  localparam int NUM_STAGES  = 4;
  localparam int FIFO_DEPTH  = 32;
  localparam int PTR_W       = 5;
  localparam int MAG_W       = 33;
  localparam int QUO_W       = 34;
  localparam int STEP_W      = 6;

  localparam logic [4:0]  MAX_RESULTS = 5'd16;
  localparam logic [2:0]  OUT_STAGE   = 3'd4;
  localparam logic [30:0] CLIP_SIZE_RESET = 31'h1000_0000;

  localparam logic [1:0] CFG_CLIP_SIZE    = 2'd0;
  localparam logic [1:0] CFG_CLIP_MARGIN  = 2'd1;
  localparam logic [1:0] CFG_CLOSE_OUTPUT = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vtx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_EDGE,
    S_CROSS,
    S_PUSHE,
    S_EMIT,
    S_FIN,
    S_FIN2,
    S_CLEAR
  } top_state_t;

  typedef enum logic [1:0] {
    CR_IDLE,
    CR_MUL,
    CR_DIV,
    CR_FIN
  } cross_state_t;

endpackage

/* rtl/core/pcs_if.sv */
// Handshake channels of the polygon clipper: vertices, results, configuration.
interface pcs_vert_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic               ring_end;
  modport source (output valid, output vert_x, output vert_y, output ring_end, input ready);
  modport sink   (input valid, input vert_x, input vert_y, input ring_end, output ready);
endinterface

interface pcs_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               ring_done;
  logic               ring_empty;
  modport source (output valid, output out_x, output out_y, output ring_done,
                  output ring_empty, input ready);
  modport sink   (input valid, input out_x, input out_y, input ring_done,
                  input ring_empty, output ready);
endinterface

interface pcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/pcs_cross.sv */
// Iterative edge/plane crossing unit: shift-add multiply, then restoring divide.
module pcs_cross import pcs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  vtx_t               s,
  input  vtx_t               e,
  input  logic [1:0]         plane_sel,
  input  logic signed [31:0] lo,
  input  logic signed [31:0] hi,
  output logic               done,
  output vtx_t               cross_v
);

  cross_state_t st, st_next;
  logic [STEP_W-1:0] step;

  logic signed [31:0] f_r, a_r;
  logic               on_y_r, neg_r;
  logic [MAG_W-1:0]   mcand, mq, dmag;
  logic [MAG_W:0]     acc;
  logic [MAG_W-1:0]   rem;
  logic [QUO_W-1:0]   nsrc, quo;

  // operand setup
  logic signed [31:0] f, cs, ce, a, b;
  logic signed [33:0] ds, de;
  logic signed [34:0] den;
  logic signed [32:0] diff;
  logic [33:0]        ds_abs;
  logic [34:0]        den_abs;
  logic [32:0]        diff_abs;

  always_comb begin
    f  = plane_sel[0] ? hi : lo;
    cs = plane_sel[1] ? s.y : s.x;
    ce = plane_sel[1] ? e.y : e.x;
    a  = plane_sel[1] ? s.x : s.y;
    b  = plane_sel[1] ? e.x : e.y;
    ds = 34'(cs) - 34'(f);
    de = 34'(ce) - 34'(f);
    den = 35'(ds) - 35'(de);
    diff = 33'(b) - 33'(a);
    ds_abs   = ds[33] ? 34'(-ds) : 34'(ds);
    den_abs  = den[34] ? 35'(-den) : 35'(den);
    diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
  end

  // iteration datapath
  logic [MAG_W:0]     acc_add;
  logic [2*MAG_W:0]   numer;
  logic [MAG_W:0]     trial, dd, trial_sub;
  logic               ge;
  logic [QUO_W-1:0]   q;
  logic signed [35:0] qext, off, sum;
  logic signed [31:0] satv;

  always_comb begin
    acc_add   = acc + (mq[0] ? {1'b0, mcand} : '0);
    numer     = {acc[MAG_W-1:0], mq, 1'b0} + (2*MAG_W+1)'(dmag);
    trial     = {rem, nsrc[QUO_W-1]};
    dd        = {dmag, 1'b0};
    ge        = trial >= dd;
    trial_sub = trial - dd;
    q         = (dmag == '0) ? '0 : quo;
    qext      = $signed({2'b00, q});
    off       = neg_r ? -qext : qext;
    sum       = 36'(a_r) + off;
    if (sum > 36'sd2147483647) begin
      satv = 32'sh7FFF_FFFF;
    end else if (sum < -36'sd2147483648) begin
      satv = 32'sh8000_0000;
    end else begin
      satv = sum[31:0];
    end
  end

  always_comb begin
    st_next = st;
    case (st)
      CR_IDLE: if (start) st_next = CR_MUL;
      CR_MUL:  if (step == STEP_W'(MAG_W - 1)) st_next = CR_DIV;
      CR_DIV:  if (step == STEP_W'(QUO_W)) st_next = CR_FIN;
      CR_FIN:  st_next = CR_IDLE;
      default: st_next = CR_IDLE;
    endcase
  end

  always_comb begin
    done = (st == CR_FIN);
    if (on_y_r) begin
      cross_v.x = satv;
      cross_v.y = f_r;
    end else begin
      cross_v.x = f_r;
      cross_v.y = satv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= CR_IDLE;
      step <= '0;
    end else begin
      st <= st_next;
      case (st)
        CR_IDLE: begin
          step   <= '0;
          f_r    <= f;
          a_r    <= a;
          on_y_r <= plane_sel[1];
          neg_r  <= diff[32] ^ ds[33] ^ den[34];
          mcand  <= diff_abs;
          mq     <= ds_abs[MAG_W-1:0];
          dmag   <= den_abs[MAG_W-1:0];
          acc    <= '0;
        end
        CR_MUL: begin
          acc  <= {1'b0, acc_add[MAG_W:1]};
          mq   <= {acc_add[0], mq[MAG_W-1:1]};
          step <= (step == STEP_W'(MAG_W - 1)) ? '0 : step + 1'b1;
        end
        CR_DIV: begin
          // first cycle loads the remainder from the top numerator bits
          if (step == '0) begin
            rem  <= numer[2*MAG_W:QUO_W];
            nsrc <= numer[QUO_W-1:0];
            quo  <= '0;
          end else begin
            rem  <= ge ? trial_sub[MAG_W-1:0] : trial[MAG_W-1:0];
            quo  <= {quo[QUO_W-2:0], ge};
            nsrc <= {nsrc[QUO_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
        end
        default: step <= '0;
      endcase
    end
  end

  cr_no_restart: assert property (@(posedge clk) disable iff (rst)
    (st != CR_IDLE) |-> !start)
    else $error("crossing start while unit busy");
  cr_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    (st == CR_MUL && st_next == CR_DIV) |=> (step == '0 ? 1'b0 : 1'b1) || st == CR_DIV)
    else $error("multiply did not hand over to divide");
  cr_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("crossing done held longer than one cycle");

endmodule

/* rtl/core/polygon_clip_to_square.sv */
// Top level: streaming four-plane polygon ring clipper with a shared crossing unit.
//
//  channel | dir | payload                               | handshake
//  vert    | in  | vert_x, vert_y, ring_end              | valid/ready
//  res     | out | out_x, out_y, ring_done, ring_empty   | valid/ready
//  cfg     | in  | index, data                           | valid/ready (always ready)
//
// Each vertex runs stage by stage through a 32-entry vertex queue with a registered read,
// and each plane crossing goes through the shared multiply/divide unit. A ring end adds
// the closing edges and up to two final results. vert is not ready until the item is done.
// A stalled result output holds the sequencer, unless the per-item result cap is reached.
// Reset is synchronous and clears all ring state at once; no clearing pass.
module polygon_clip_to_square import pcs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  pcs_vert_if.sink vert,
  pcs_res_if.source res,
  pcs_cfg_if.sink  cfg
);

  logic [30:0] clip_size;
  logic [29:0] clip_margin;
  logic        close_output;

  top_state_t state, state_next, em_ret;

  vtx_t             fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] head, tail, cur_cnt, nxt_cnt;
  logic [2:0]       stage;
  logic             end_r, closing_done;
  logic             rd_ok;

  vtx_t                  first_v [NUM_STAGES];
  vtx_t                  prev_v  [NUM_STAGES];
  logic [NUM_STAGES-1:0] has;

  vtx_t       first_out, last_out;
  logic       out_nz;
  vtx_t       s_r, e_r, em_v;
  logic       em_done, em_empty;
  logic [4:0] res_cnt;

  logic o_valid, o_done, o_empty;
  vtx_t o_v;

  logic signed [31:0] bound_lo, bound_hi;
  logic [32:0]        hi_sum;

  always_comb begin
    hi_sum   = {2'b00, clip_size} + {3'b000, clip_margin};
    bound_hi = (hi_sum > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(hi_sum[31:0]);
    bound_lo = -$signed({2'b00, clip_margin});
  end

  function automatic logic in_plane(vtx_t p, logic [1:0] k,
                                    logic signed [31:0] lo, logic signed [31:0] hi);
    logic signed [31:0] c;
    begin
      c = k[1] ? p.y : p.x;
      return k[0] ? (c <= hi) : (c >= lo);
    end
  endfunction

  logic [1:0] sel;
  logic       at_out, sin, ein, dup, slot_free, emit_load, pop, push, cx_start, cx_done;
  vtx_t       head_v, in_v, push_v, cx_v;

  always_comb begin
    sel       = stage[1:0];
    at_out    = (stage == OUT_STAGE);
    in_v.x    = vert.vert_x;
    in_v.y    = vert.vert_y;
    dup       = vert.ring_end && has[0] && (in_v == first_v[0]);
    sin       = in_plane(s_r, sel, bound_lo, bound_hi);
    ein       = in_plane(e_r, sel, bound_lo, bound_hi);
    slot_free = !o_valid || res.ready;
  end

  pcs_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .start     (cx_start),
    .s         (s_r),
    .e         (e_r),
    .plane_sel (sel),
    .lo        (bound_lo),
    .hi        (bound_hi),
    .done      (cx_done),
    .cross_v   (cx_v)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (vert.valid) state_next = S_FETCH;
      S_FETCH: begin
        if (at_out) begin
          if (cur_cnt != '0) begin
            if (rd_ok) state_next = out_nz ? S_EMIT : S_FETCH;
          end else begin
            state_next = end_r ? S_FIN : S_IDLE;
          end
        end else if (cur_cnt != '0) begin
          if (rd_ok) state_next = has[sel] ? S_EDGE : S_FETCH;
        end else if (end_r && has[sel] && !closing_done) begin
          state_next = S_EDGE;
        end
      end
      S_EDGE:  state_next = (sin ^ ein) ? S_CROSS : S_FETCH;
      S_CROSS: if (cx_done) state_next = ein ? S_PUSHE : S_FETCH;
      S_PUSHE: state_next = S_FETCH;
      S_EMIT:  if (res_cnt >= MAX_RESULTS || slot_free) state_next = em_ret;
      S_FIN:   state_next = S_EMIT;
      S_FIN2:  state_next = S_EMIT;
      S_CLEAR: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    vert.ready = (state == S_IDLE);
    cfg.ready  = 1'b1;
    cx_start   = (state == S_EDGE) && (sin ^ ein);
    pop        = (state == S_FETCH) && (cur_cnt != '0) && rd_ok;
    emit_load  = (state == S_EMIT) && (res_cnt < MAX_RESULTS) && slot_free;
    push       = 1'b0;
    push_v     = e_r;
    case (state)
      S_IDLE:  begin
        push   = vert.valid && !dup;
        push_v = in_v;
      end
      S_EDGE:  push = sin && ein;
      S_CROSS: begin
        push   = cx_done;
        push_v = cx_v;
      end
      S_PUSHE: push = 1'b1;
      default: push = 1'b0;
    endcase
    res.valid      = o_valid;
    res.out_x      = o_v.x;
    res.out_y      = o_v.y;
    res.ring_done  = o_done;
    res.ring_empty = o_empty;
  end

  always_ff @(posedge clk) begin
    if (push) fifo[tail] <= push_v;
    head_v <= fifo[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      em_ret       <= S_IDLE;
      clip_size    <= CLIP_SIZE_RESET;
      clip_margin  <= '0;
      close_output <= 1'b0;
      head         <= '0;
      tail         <= '0;
      cur_cnt      <= '0;
      nxt_cnt      <= '0;
      stage        <= '0;
      end_r        <= 1'b0;
      closing_done <= 1'b0;
      rd_ok        <= 1'b0;
      has          <= '0;
      out_nz       <= 1'b0;
      res_cnt      <= '0;
      o_valid      <= 1'b0;
    end else begin
      state <= state_next;

      // read data is good once the head has held still with no write to it
      rd_ok <= !pop && !(push && (tail == head));

      if (cfg.valid) begin
        case (cfg.index)
          CFG_CLIP_SIZE:    clip_size    <= cfg.data[30:0];
          CFG_CLIP_MARGIN:  clip_margin  <= cfg.data[29:0];
          CFG_CLOSE_OUTPUT: close_output <= cfg.data[0];
          default: ;
        endcase
      end

      if (emit_load) begin
        o_valid <= 1'b1;
        o_v     <= em_v;
        o_done  <= em_done;
        o_empty <= em_empty;
        res_cnt <= res_cnt + 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end

      if (push) tail <= tail + 1'b1;
      if (push && state != S_IDLE) nxt_cnt <= nxt_cnt + 1'b1;

      case (state)
        S_IDLE: if (vert.valid) begin
          cur_cnt      <= PTR_W'(!dup);
          nxt_cnt      <= '0;
          stage        <= '0;
          end_r        <= vert.ring_end;
          closing_done <= 1'b0;
          res_cnt      <= '0;
        end
        S_FETCH: begin
          if (pop) begin
            head    <= head + 1'b1;
            cur_cnt <= cur_cnt - 1'b1;
            if (at_out) begin
              last_out <= head_v;
              if (out_nz) begin
                em_v     <= last_out;
                em_done  <= 1'b0;
                em_empty <= 1'b0;
                em_ret   <= S_FETCH;
              end else begin
                first_out <= head_v;
                out_nz    <= 1'b1;
              end
            end else if (!has[sel]) begin
              has[sel]     <= 1'b1;
              first_v[sel] <= head_v;
              prev_v[sel]  <= head_v;
            end else begin
              s_r         <= prev_v[sel];
              e_r         <= head_v;
              prev_v[sel] <= head_v;
            end
          end else if (!at_out && cur_cnt == '0) begin
            if (end_r && has[sel] && !closing_done) begin
              // closing edge of this plane, back to its first vertex
              s_r          <= prev_v[sel];
              e_r          <= first_v[sel];
              closing_done <= 1'b1;
            end else begin
              stage        <= stage + 1'b1;
              cur_cnt      <= nxt_cnt;
              nxt_cnt      <= '0;
              closing_done <= 1'b0;
            end
          end
        end
        S_FIN: begin
          if (!out_nz) begin
            em_v     <= '0;
            em_done  <= 1'b1;
            em_empty <= 1'b1;
            em_ret   <= S_CLEAR;
          end else if (close_output && (first_out != last_out)) begin
            em_v     <= last_out;
            em_done  <= 1'b0;
            em_empty <= 1'b0;
            em_ret   <= S_FIN2;
          end else begin
            em_v     <= last_out;
            em_done  <= 1'b1;
            em_empty <= 1'b0;
            em_ret   <= S_CLEAR;
          end
        end
        S_FIN2: begin
          em_v     <= first_out;
          em_done  <= 1'b1;
          em_empty <= 1'b0;
          em_ret   <= S_CLEAR;
        end
        S_CLEAR: begin
          has    <= '0;
          out_nz <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ring_empty) |-> res.ring_done)
    else $error("empty ring result without ring_done");
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ring_empty) |-> (res.out_x == '0 && res.out_y == '0))
    else $error("empty ring result with nonzero coordinates");
  a_res_cap: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= MAX_RESULTS)
    else $error("result count per item above limit");
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (cur_cnt == '0 && head == tail))
    else $error("vertex queue not drained between items");

endmodule
